// ===== design/spq_pkg.sv =====
// Shared constants and types of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 16;
    localparam int TAG_BITS_DEF  = 16;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

// ===== design/spq_req_if.sv =====
// Request channel of the sorted priority queue.
interface spq_req_if #(
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic signed [PRIO_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]         payload;

    modport source (output valid, output req_type, output priority_req,
                    output payload, input ready);
    modport sink   (input valid, input req_type, input priority_req,
                    input payload, output ready);
endinterface

// ===== design/spq_rsp_if.sv =====
// Response channel of the sorted priority queue.
interface spq_rsp_if #(
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
    parameter int CNT_W     = $clog2(spq_pkg::DEPTH_DEF + 1)
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [TAG_BITS-1:0]         head_payload;
    logic signed [PRIO_BITS-1:0] head_priority;
    logic [CNT_W-1:0]            entry_count;

    modport source (output valid, output status, output head_payload,
                    output head_priority, output entry_count, input ready);
    modport sink   (input valid, input status, input head_payload,
                    input head_priority, input entry_count, output ready);
endinterface

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue top level: a chain of shifting cells with a registered response.
// The response to a request is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are drained; every cell compares and shifts in the same cycle.
// A request is taken while the response register is empty or being drained.
// Reset clears the entry count and the response valid; the cell contents are left as they are.
module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spq_req_if.sink          i_req,
    spq_rsp_if.source        o_rsp
);
    import spq_pkg::*;

    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_rsp_valid;
    logic [1:0]                  r_status, n_status;
    logic [TAG_BITS-1:0]         r_head_tag, n_head_tag;
    logic signed [PRIO_BITS-1:0] r_head_prio, n_head_prio;

    logic                        accept;
    logic                        full;
    logic                        empty;
    t_cell_ctl                   ctl;

    logic                        w_ge   [DEPTH];
    logic signed [PRIO_BITS-1:0] w_prio [DEPTH];
    logic [TAG_BITS-1:0]         w_tag  [DEPTH];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);

    always_comb begin
        ctl         = '0;
        n_count     = r_count;
        n_status    = ST_OK;
        n_head_tag  = '0;
        n_head_prio = '0;
        unique case (i_req.req_type) inside
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.insert = accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE, REQ_PEEK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head_tag  = w_tag[0];
                    n_head_prio = w_prio[0];
                    if (i_req.req_type == REQ_REMOVE) begin
                        ctl.remove = accept;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                        prev_ge;
            logic signed [PRIO_BITS-1:0] prev_prio, next_prio;
            logic [TAG_BITS-1:0]         prev_tag, next_tag;

            if (gi == 0) begin : g_first
                assign prev_ge   = 1'b1;
                assign prev_prio = '0;
                assign prev_tag  = '0;
            end else begin : g_mid
                assign prev_ge   = w_ge[gi-1];
                assign prev_prio = w_prio[gi-1];
                assign prev_tag  = w_tag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign next_prio = '0;
                assign next_tag  = '0;
            end else begin : g_inner
                assign next_prio = w_prio[gi+1];
                assign next_tag  = w_tag[gi+1];
            end

            spq_cell #(
                .PRIO_BITS (PRIO_BITS),
                .TAG_BITS  (TAG_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occupied  (CNT_W'(gi) < r_count),
                .i_new_prio  (i_req.priority_req),
                .i_new_tag   (i_req.payload),
                .i_prev_ge   (prev_ge),
                .i_prev_prio (prev_prio),
                .i_prev_tag  (prev_tag),
                .i_next_prio (next_prio),
                .i_next_tag  (next_tag),
                .o_ge        (w_ge[gi]),
                .o_prio      (w_prio[gi]),
                .o_tag       (w_tag[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_head_tag  <= n_head_tag;
            r_head_prio <= n_head_prio;
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.head_payload  = r_head_tag;
    assign o_rsp.head_priority = r_head_prio;
    assign o_rsp.entry_count   = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.req_type == REQ_INSERT && !full
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted insert did not add an entry");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp.valid)
        else $error("accepted request produced no response");

    a_full_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.req_type == REQ_INSERT && full
        |=> o_rsp.status == ST_FULL && $stable(r_count))
        else $error("insert into full queue was not rejected");
`endif
endmodule

// ===== design/spq_cell.sv =====
// One slot of the sorted shift chain: holds one entry and moves it on insert or remove.
module spq_cell #(
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  spq_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_occupied,
    input  logic signed [PRIO_BITS-1:0] i_new_prio,
    input  logic [TAG_BITS-1:0]         i_new_tag,
    input  logic                        i_prev_ge,
    input  logic signed [PRIO_BITS-1:0] i_prev_prio,
    input  logic [TAG_BITS-1:0]         i_prev_tag,
    input  logic signed [PRIO_BITS-1:0] i_next_prio,
    input  logic [TAG_BITS-1:0]         i_next_tag,
    output logic                        o_ge,
    output logic signed [PRIO_BITS-1:0] o_prio,
    output logic [TAG_BITS-1:0]         o_tag
);
    import spq_pkg::*;

    logic signed [PRIO_BITS-1:0] r_prio, n_prio;
    logic [TAG_BITS-1:0]         r_tag, n_tag;

    // A held entry of equal or greater priority stays ahead of the new one.
    assign o_ge = i_occupied && (r_prio >= i_new_prio);

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctl.insert && !o_ge) begin
            if (i_prev_ge) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end else begin
                n_prio = i_prev_prio;
                n_tag  = i_prev_tag;
            end
        end else if (i_ctl.remove) begin
            n_prio = i_next_prio;
            n_tag  = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: random and directed requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int          CNT_W       = $clog2(DEPTH_DEF + 1);
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          RANDOM_REQS = 980;
    localparam int          QUIET_TAIL  = 120;
    localparam int          HOLD_AT     = 400;
    localparam int          HOLD_CYCLES = 80;
    localparam int          IDLE_LIMIT  = 2000;

    typedef struct {
        logic [1:0]                      kind;
        logic signed [PRIO_BITS_DEF-1:0] prio;
        logic [TAG_BITS_DEF-1:0]         tag;
        bit                              drain_first;
    } t_req;

    typedef struct {
        logic [1:0]                      status;
        logic [TAG_BITS_DEF-1:0]         head_tag;
        logic signed [PRIO_BITS_DEF-1:0] head_prio;
        logic [CNT_W-1:0]                count;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the queue contents, head at index 0.
    logic signed [PRIO_BITS_DEF-1:0] held_prio [DEPTH_DEF];
    logic [TAG_BITS_DEF-1:0]         held_tag  [DEPTH_DEF];
    int                              held_cnt;

    t_req pending_reqs [$];
    t_rsp expected_rsp [$];
    t_req drv_item;
    t_rsp want;
    t_req seen_req;

    int n_errors;
    int n_req_accepted;
    int idle_cycles;
    bit req_taken;
    int send_gap;
    int stall_left;
    int hold_left;
    bit hold_done;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("%0t ns MISMATCH: %s", $time, msg);
    endtask

    // Applies one request to the shadow queue and returns the response it must produce.
    function automatic t_rsp queue_apply(input t_req r);
        t_rsp res;
        int   pos;
        res.status    = ST_OK;
        res.head_tag  = '0;
        res.head_prio = '0;
        case (r.kind)
            REQ_INSERT: begin
                if (held_cnt >= DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    // New entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < held_cnt && held_prio[pos] >= r.prio) pos++;
                    for (int k = held_cnt; k > pos; k--) begin
                        held_prio[k] = held_prio[k-1];
                        held_tag[k]  = held_tag[k-1];
                    end
                    held_prio[pos] = r.prio;
                    held_tag[pos]  = r.tag;
                    held_cnt++;
                end
            end
            REQ_REMOVE, REQ_PEEK: begin
                if (held_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.head_prio = held_prio[0];
                    res.head_tag  = held_tag[0];
                    if (r.kind == REQ_REMOVE) begin
                        for (int k = 1; k < held_cnt; k++) begin
                            held_prio[k-1] = held_prio[k];
                            held_tag[k-1]  = held_tag[k];
                        end
                        held_cnt--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = held_cnt[CNT_W-1:0];
        return res;
    endfunction

    task automatic add_req(input logic [1:0] kind, input logic signed [15:0] prio,
                           input logic [15:0] tag, input bit drain_first);
        t_req r;
        r.kind        = kind;
        r.prio        = prio;
        r.tag         = tag;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [15:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 16'(int'($urandom_range(0, 4)) - 2);
        if (sel < 50) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return 16'($urandom);
    endfunction

    task automatic build_stimulus();
        int mode;
        int seg_len;
        int sel;
        int made;
        logic [1:0] kind;
        // Empty queue, unused code, then a fill past full with extremes and equal priorities, a peek and removes.
        add_req(REQ_REMOVE, 16'sh0000, 16'h0000, 1'b0);
        add_req(REQ_PEEK,   16'sh7FFF, 16'hFFFF, 1'b0);
        add_req(REQ_UNUSED, 16'sh8000, 16'hFFFF, 1'b0);
        add_req(REQ_INSERT, 16'sh0000, 16'h1111, 1'b0);
        add_req(REQ_INSERT, 16'sh7FFF, 16'hFFFF, 1'b0);
        add_req(REQ_INSERT, 16'sh8000, 16'h0000, 1'b0);
        add_req(REQ_INSERT, 16'sh0000, 16'h2222, 1'b0);
        add_req(REQ_INSERT, 16'sh7FFF, 16'h0001, 1'b0);
        add_req(REQ_INSERT, -16'sd1,   16'hAAAA, 1'b0);
        add_req(REQ_INSERT, 16'sh0001, 16'h5555, 1'b0);
        add_req(REQ_INSERT, 16'sh8000, 16'h8000, 1'b0);
        add_req(REQ_INSERT, 16'sh0000, 16'h3333, 1'b0);
        add_req(REQ_INSERT, 16'sh7FFE, 16'h7FFF, 1'b0);
        add_req(REQ_INSERT, 16'sh8001, 16'h0002, 1'b0);
        add_req(REQ_INSERT, -16'sd1,   16'hBBBB, 1'b0);
        add_req(REQ_INSERT, 16'sh1234, 16'h4321, 1'b0);
        add_req(REQ_INSERT, 16'sh0000, 16'h4444, 1'b0);
        add_req(REQ_INSERT, 16'sh7FFF, 16'h0003, 1'b0);
        add_req(REQ_INSERT, 16'sh8000, 16'h0004, 1'b0);
        add_req(REQ_INSERT, 16'sh7FFF, 16'hDEAD, 1'b0);
        add_req(REQ_UNUSED, 16'sh7FFF, 16'hFFFF, 1'b0);
        add_req(REQ_PEEK,   16'sh0000, 16'h0000, 1'b0);
        add_req(REQ_REMOVE, 16'sh0000, 16'h0000, 1'b0);
        add_req(REQ_REMOVE, 16'sh0000, 16'h0000, 1'b0);

        // Random part: segments that lean toward filling, draining or a mix.
        made = 0;
        while (made < RANDOM_REQS) begin
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(30, 60);
            for (int i = 0; i < seg_len; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    kind = REQ_UNUSED;
                else if (mode == 0)
                    kind = (sel < 75) ? REQ_INSERT : (sel < 90 ? REQ_REMOVE : REQ_PEEK);
                else if (mode == 1)
                    kind = (sel < 28) ? REQ_INSERT : (sel < 85 ? REQ_REMOVE : REQ_PEEK);
                else
                    kind = (sel < 50) ? REQ_INSERT : (sel < 80 ? REQ_REMOVE : REQ_PEEK);
                // The sender waits for all responses before the first random request and
                // once midway.
                add_req(kind, pick_prio(), 16'($urandom), made == 0 || made == 500);
                if (kind != REQ_UNUSED) made++;
            end
        end
    endtask

    initial begin
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_INSERT;
        req_if.priority_req = '0;
        req_if.payload      = '0;
        rsp_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        held_cnt            = 0;
        n_errors            = 0;
        n_req_accepted      = 0;
        idle_cycles         = 0;
        req_taken           = 1'b0;
        send_gap            = 0;
        stall_left          = 0;
        hold_left           = 0;
        hold_done           = 1'b0;
        build_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pending_reqs.size() != 0 || req_if.valid || expected_rsp.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
            // Request still waiting for the block: hold it steady.
        end else if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_rsp.size() != 0)) begin
            req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 99) < 6) begin
            send_gap = $urandom_range(1, 18) - 1;
            req_if.valid <= 1'b0;
        end else begin
            drv_item = pending_reqs.pop_front();
            req_if.req_type     <= drv_item.kind;
            req_if.priority_req <= drv_item.prio;
            req_if.payload      <= drv_item.tag;
            req_if.valid        <= 1'b1;
        end
    end

    // Response sink with random stalls and one long hold-off that backs the block up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (!hold_done && n_req_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 99) < 6) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request and scores each accepted response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_if.status, want.status));
                    if (rsp_if.head_payload !== want.head_tag)
                        report_mismatch($sformatf("head_payload %h, expected %h",
                                                  rsp_if.head_payload, want.head_tag));
                    if (rsp_if.head_priority !== want.head_prio)
                        report_mismatch($sformatf("head_priority %0d, expected %0d",
                                                  rsp_if.head_priority, want.head_prio));
                    if (rsp_if.entry_count !== want.count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  rsp_if.entry_count, want.count));
                end
            end
            if (req_if.valid && req_if.ready) begin
                seen_req.kind        = req_if.req_type;
                seen_req.prio        = req_if.priority_req;
                seen_req.tag         = req_if.payload;
                seen_req.drain_first = 1'b0;
                expected_rsp.push_back(queue_apply(seen_req));
                n_req_accepted++;
            end
            req_taken <= req_if.valid && req_if.ready;
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
